FILE: sv/pcr_pkg.sv
package pcr_pkg;

   localparam int HASH_BYTES = 32;
   localparam int MSG_BITS   = 2 * HASH_BYTES * 8;
   localparam int ROUNDS     = 64;
   localparam int ROUND_W    = $clog2(ROUNDS);

   localparam logic [31:0] PAD_MARK = 32'h8000_0000;
   localparam logic [31:0] PAD_LEN  = 32'(MSG_BITS);

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // controller -> datapath command, at most one strobe per cycle
   typedef struct packed {
      logic               load;    // take request + old PCR, init state
      logic               round;   // one compression round
      logic               fold;    // add to chain, load padding block
      logic               commit;  // add to chain, write PCR
      logic [ROUND_W-1:0] rnd;     // round index for K
   } pcr_cmd_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

FILE: sv/pcr_extend_sha256_core.sv
// Channel | Handshake            | Payload
// --------+----------------------+------------------------------------------
// req     | req_valid/req_stall  | req_value_word_0..3 : digest, big-endian
// rsp     | rsp_valid/rsp_stall  | rsp_pcr_word_0..3   : new PCR, big-endian
//
// One request runs as follows: the accept edge loads the block, then 64 rounds,
// a fold step, 64 rounds of the padding block and a commit step. The SHA-256
// compression unit is single and does one round per cycle.
// Synchronous active-high reset clears the PCR to zero and idles the controller.
// req_stall is high from acceptance until commit. The PCR register is the
// response register, so commit waits while a previous response is still stalled.
module pcr_extend_sha256_core
   import pcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value_word_0,
   input  logic [63:0] req_value_word_1,
   input  logic [63:0] req_value_word_2,
   input  logic [63:0] req_value_word_3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_pcr_word_0,
   output logic [63:0] rsp_pcr_word_1,
   output logic [63:0] rsp_pcr_word_2,
   output logic [63:0] rsp_pcr_word_3
);

   pcr_cmd_type cmd;

   // sequencer: load, two 64-round passes, fold, commit
   pcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // message window, working variables, chaining value and PCR
   pcr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value_word_0 (req_value_word_0),
      .req_value_word_1 (req_value_word_1),
      .req_value_word_2 (req_value_word_2),
      .req_value_word_3 (req_value_word_3),
      .pcr_word_0       (rsp_pcr_word_0),
      .pcr_word_1       (rsp_pcr_word_1),
      .pcr_word_2       (rsp_pcr_word_2),
      .pcr_word_3       (rsp_pcr_word_3)
   );

`ifndef SYNTHESIS
   // at most one datapath operation per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.round, cmd.fold, cmd.commit}))
      else $error("multiple datapath commands in one cycle");

   // load happens only on an accepted request
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_valid && !req_stall))
      else $error("load without accepted request");

   // one request in flight: stall right after acceptance
   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while busy");

   // commit always raises a response
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit without response");
`endif

endmodule

FILE: sv/pcr_ctrl.sv
module pcr_ctrl
   import pcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pcr_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RND1 = 5'b00010,
      ST_FIN1 = 5'b00100,
      ST_RND2 = 5'b01000,
      ST_FIN2 = 5'b10000
   } pcr_state_type;

   localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

   pcr_state_type      state_ff, state_in;
   logic [ROUND_W-1:0] rnd_ff, rnd_in;
   logic               rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      rnd_in     = rnd_ff;
      cmd        = '0;
      cmd.rnd    = rnd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               rnd_in   = '0;
               state_in = ST_RND1;
            end
         end
         ST_RND1: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 1'b1;
            if (rnd_ff == LAST_ROUND) state_in = ST_FIN1;
         end
         ST_FIN1: begin
            cmd.fold = 1'b1;
            rnd_in   = '0;
            state_in = ST_RND2;
         end
         ST_RND2: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 1'b1;
            if (rnd_ff == LAST_ROUND) state_in = ST_FIN2;
         end
         ST_FIN2: begin
            // PCR doubles as the response register: hold while it is unread
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/pcr_dp.sv
module pcr_dp
   import pcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  pcr_cmd_type cmd,
   input  logic [63:0] req_value_word_0,
   input  logic [63:0] req_value_word_1,
   input  logic [63:0] req_value_word_2,
   input  logic [63:0] req_value_word_3,
   output logic [63:0] pcr_word_0,
   output logic [63:0] pcr_word_1,
   output logic [63:0] pcr_word_2,
   output logic [63:0] pcr_word_3
);

   logic [31:0] w_ff    [16];
   logic [31:0] w_in    [16];
   logic [31:0] work_ff [8];
   logic [31:0] work_in [8];
   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];
   logic [63:0] pcr_ff  [4];
   logic [63:0] pcr_in  [4];

   logic [63:0] req_w   [4];
   logic [31:0] sum     [8];
   logic [31:0] w_next;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] ch;
   logic [31:0] maj;

   assign req_w[0] = req_value_word_0;
   assign req_w[1] = req_value_word_1;
   assign req_w[2] = req_value_word_2;
   assign req_w[3] = req_value_word_3;

   // window holds W[t..t+15]; compute W[t+16]
   assign w_next = w_ff[0] + small_sigma0(w_ff[1]) + w_ff[9] + small_sigma1(w_ff[14]);

   assign ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
              ^ (work_ff[1] & work_ff[2]);
   assign t1  = work_ff[7] + big_sigma1(work_ff[4]) + ch + ROUND_K[cmd.rnd] + w_ff[0];
   assign t2  = big_sigma0(work_ff[0]) + maj;

   always_comb begin
      for (int i = 0; i < 8; i++) sum[i] = hash_ff[i] + work_ff[i];
   end

   always_comb begin
      w_in    = w_ff;
      work_in = work_ff;
      hash_in = hash_ff;
      pcr_in  = pcr_ff;
      if (cmd.load) begin
         for (int i = 0; i < 4; i++) begin
            w_in[2*i]     = pcr_ff[i][63:32];
            w_in[2*i+1]   = pcr_ff[i][31:0];
            w_in[8+2*i]   = req_w[i][63:32];
            w_in[8+2*i+1] = req_w[i][31:0];
         end
         work_in = INIT_H;
         hash_in = INIT_H;
      end
      if (cmd.round) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15]   = w_next;
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
      if (cmd.fold) begin
         hash_in = sum;
         work_in = sum;
         for (int i = 0; i < 16; i++) w_in[i] = '0;
         w_in[0]  = PAD_MARK;
         w_in[15] = PAD_LEN;
      end
      if (cmd.commit) begin
         for (int i = 0; i < 4; i++) pcr_in[i] = {sum[2*i], sum[2*i+1]};
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      work_ff <= work_in;
      hash_ff <= hash_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) pcr_ff[i] <= '0;
      end else begin
         pcr_ff <= pcr_in;
      end
   end

   assign pcr_word_0 = pcr_ff[0];
   assign pcr_word_1 = pcr_ff[1];
   assign pcr_word_2 = pcr_ff[2];
   assign pcr_word_3 = pcr_ff[3];

endmodule
